@@ hdl/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset condition holds.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

@@ hdl/shp_pkg.sv @@
`timescale 1ns / 1ps

package shp_pkg;

  localparam int PIX_W       = 24;
  localparam int CHAN_W      = 8;
  localparam int NUM_CHAN    = 3;
  localparam int ROW_W       = 12;
  localparam int CFG_W       = 12;
  localparam int ACC_W       = 13;
  localparam int WIN_SIZE    = 9;
  localparam int CENTER_IDX  = 4;
  localparam int CENTER_GAIN = 10;
  localparam int WIDTH_MIN   = 3;
  localparam int WIDTH_RESET = 640;
  localparam int CHAN_MAX    = 255;

  localparam logic [ROW_W-1:0] ROW_LIMIT = '1;

  typedef logic [PIX_W-1:0]         pix_t;
  typedef logic [CHAN_W-1:0]        chan_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

endpackage

@@ hdl/shp_line_ram.sv @@
`timescale 1ns / 1ps

module shp_line_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output shp_pkg::pix_t rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  shp_pkg::pix_t wr_data
);

  shp_pkg::pix_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data is held while no new read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/shp_kernel.sv @@
`timescale 1ns / 1ps

module shp_kernel (
  input  shp_pkg::pix_t win [shp_pkg::WIN_SIZE],
  output shp_pkg::pix_t pix_out
);

  always_comb begin
    shp_pkg::acc_t  acc;
    shp_pkg::chan_t v;
    pix_out = '0;
    for (int ch = 0; ch < shp_pkg::NUM_CHAN; ch++) begin
      v   = win[shp_pkg::CENTER_IDX][ch*shp_pkg::CHAN_W +: shp_pkg::CHAN_W];
      acc = shp_pkg::acc_t'({{(shp_pkg::ACC_W-shp_pkg::CHAN_W){1'b0}}, v}) *
            shp_pkg::acc_t'(shp_pkg::CENTER_GAIN);
      for (int k = 0; k < shp_pkg::WIN_SIZE; k++) begin
        if (k != shp_pkg::CENTER_IDX) begin
          v   = win[k][ch*shp_pkg::CHAN_W +: shp_pkg::CHAN_W];
          acc = acc - shp_pkg::acc_t'({{(shp_pkg::ACC_W-shp_pkg::CHAN_W){1'b0}}, v});
        end
      end
      if (acc < 0) begin
        pix_out[ch*shp_pkg::CHAN_W +: shp_pkg::CHAN_W] = '0;
      end else if (acc > shp_pkg::acc_t'(shp_pkg::CHAN_MAX)) begin
        pix_out[ch*shp_pkg::CHAN_W +: shp_pkg::CHAN_W] = '1;
      end else begin
        pix_out[ch*shp_pkg::CHAN_W +: shp_pkg::CHAN_W] = acc[shp_pkg::CHAN_W-1:0];
      end
    end
  end

endmodule

@@ hdl/rgb_sharpen_3x3_filter_unit.sv @@
`timescale 1ns / 1ps
// The beat completing a window passes stage 1; its result is held in the result register.
// Throughput: one pixel beat per clock unless the output stalls. The line buffers are read
// on the input beat and written as that pixel leaves stage 1, and a same-column access on
// back-to-back beats is forwarded. Reset (rst_n low, synchronous) clears counters, valids
// and sets the image width to 640; line buffer contents are not cleared.
module rgb_sharpen_3x3_filter_unit #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: pixel_in [23:0]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,
  // in_tuser: frame_start [0]
  input  logic                  in_tuser,
  // out_tdata: pixel_out, center_col, center_row, zero fill
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [((shp_pkg::PIX_W + $clog2(MAX_WIDTH) + shp_pkg::ROW_W + 7) / 8) * 8 - 1:0]
                                out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [11:0]           cfg_data
);

  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int OUT_BITS  = shp_pkg::PIX_W + CW + shp_pkg::ROW_W;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;
  localparam int RST_WIDTH = (shp_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                : shp_pkg::WIDTH_RESET;

  // Configuration.
  logic [WW-1:0] width_r, width_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_data < shp_pkg::CFG_W'(shp_pkg::WIDTH_MIN)) begin
      width_nxt = WW'(shp_pkg::WIDTH_MIN);
    end else if (int'(cfg_data) > MAX_WIDTH) begin
      width_nxt = WW'(MAX_WIDTH);
    end else begin
      width_nxt = WW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WW'(RST_WIDTH);
    end else if (cfg_valid && cfg_ready) begin
      width_r <= width_nxt;
    end
  end

  // Position counters.
  logic                      in_acc;
  logic [CW-1:0]             col_r, col_nxt, col_cur;
  logic [shp_pkg::ROW_W-1:0] row_r, row_nxt, row_cur;

  assign in_acc  = in_tvalid && in_tready;
  assign col_cur = in_tuser ? '0 : col_r;
  assign row_cur = in_tuser ? '0 : row_r;

  always_comb begin
    if ((WW'(col_cur) + WW'(1)) >= width_r) begin
      col_nxt = '0;
      row_nxt = (row_cur != shp_pkg::ROW_LIMIT) ? row_cur + shp_pkg::ROW_W'(1) : row_cur;
    end else begin
      col_nxt = col_cur + CW'(1);
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage 1: pixel waits here while its line buffer reads return.
  logic                      s1_valid_r;
  shp_pkg::pix_t             s1_pix_r;
  logic [CW-1:0]             s1_col_r;
  logic [shp_pkg::ROW_W-1:0] s1_row_r;
  logic                      s1_fwd_r;
  shp_pkg::pix_t             s1_fwd_top_r, s1_fwd_mid_r;
  shp_pkg::pix_t             top_rd, mid_rd, top_eff, mid_eff;
  logic                      s1_has_res, s1_adv;
  logic                      out_valid_r;

  assign top_eff    = s1_fwd_r ? s1_fwd_top_r : top_rd;
  assign mid_eff    = s1_fwd_r ? s1_fwd_mid_r : mid_rd;
  assign s1_has_res = (s1_row_r >= shp_pkg::ROW_W'(2)) && (s1_col_r >= CW'(2));
  assign s1_adv     = s1_valid_r && (!s1_has_res || !out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // A frame start can revisit the column still sitting in stage 1, whose write
  // lands on the same edge as the new read, so that data is forwarded.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r     <= in_tdata;
      s1_col_r     <= col_cur;
      s1_row_r     <= row_cur;
      s1_fwd_r     <= s1_valid_r && (s1_col_r == col_cur);
      s1_fwd_top_r <= mid_eff;
      s1_fwd_mid_r <= s1_pix_r;
    end
  end

  shp_line_ram #(.DEPTH(MAX_WIDTH), .AW(CW)) u_upper (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_cur),
    .rd_data (top_rd),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (mid_eff)
  );

  shp_line_ram #(.DEPTH(MAX_WIDTH), .AW(CW)) u_middle (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_cur),
    .rd_data (mid_rd),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (s1_pix_r)
  );

  // Two left columns of the window, rows top to bottom: index 2*row + col.
  shp_pkg::pix_t win_r [6];
  shp_pkg::pix_t win [shp_pkg::WIN_SIZE];
  shp_pkg::pix_t sharp;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win_r[0] <= win_r[1];
      win_r[1] <= top_eff;
      win_r[2] <= win_r[3];
      win_r[3] <= mid_eff;
      win_r[4] <= win_r[5];
      win_r[5] <= s1_pix_r;
    end
  end

  assign win[0] = win_r[0];
  assign win[1] = win_r[1];
  assign win[2] = top_eff;
  assign win[3] = win_r[2];
  assign win[4] = win_r[3];
  assign win[5] = mid_eff;
  assign win[6] = win_r[4];
  assign win[7] = win_r[5];
  assign win[8] = s1_pix_r;

  shp_kernel u_kernel (
    .win     (win),
    .pix_out (sharp)
  );

  // Result register.
  logic [OUT_BITS-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_has_res) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_has_res) begin
      out_data_r <= {s1_row_r - shp_pkg::ROW_W'(1), s1_col_r - CW'(1), sharp};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);

endmodule

@@ hdl/shp_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module shp_checker #(
  parameter int MAX_WIDTH = 2048
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [((shp_pkg::PIX_W + $clog2(MAX_WIDTH) + shp_pkg::ROW_W + 7) / 8) * 8 - 1:0]
                               out_tdata
);

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int COL_LO  = shp_pkg::PIX_W;
  localparam int ROW_LO  = shp_pkg::PIX_W + CW;

  logic [CW-1:0]             chk_col;
  logic [shp_pkg::ROW_W-1:0] chk_row;

  assign chk_col = out_tdata[COL_LO +: CW];
  assign chk_row = out_tdata[ROW_LO +: shp_pkg::ROW_W];

  `ASSERT_CLK_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_tvalid)
  `ASSERT_CLK(a_stall_keeps_valid, clk, !rst_n, out_tvalid && !out_tready |=> out_tvalid)
  `ASSERT_CLK(a_stall_keeps_data, clk, !rst_n,
              out_tvalid && !out_tready |=> $stable(out_tdata))
  // A center on the top row or left column never produces a result.
  `ASSERT_CLK(a_center_inside, clk, !rst_n, out_tvalid |-> chk_col != '0 && chk_row != '0)

endmodule

bind rgb_sharpen_3x3_filter_unit shp_checker #(.MAX_WIDTH(MAX_WIDTH)) u_shp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ sim/rgb_sharpen_3x3_filter_unit_tb.sv @@
`timescale 1ns / 1ps

module rgb_sharpen_3x3_filter_unit_tb;

  localparam int MAX_W       = 2048;
  localparam int COL_W       = $clog2(MAX_W);
  localparam int OUT_W       = ((shp_pkg::PIX_W + COL_W + shp_pkg::ROW_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SQUEEZE_LEN = 400;
  localparam int RAND_ITEMS  = 780;
  localparam int DIR_ROWS    = 25;

  typedef struct packed {
    shp_pkg::pix_t             pix;
    logic [COL_W-1:0]          col;
    logic [shp_pkg::ROW_W-1:0] row;
  } sharp_result_t;

  typedef struct packed {
    shp_pkg::pix_t pix;
    logic          fs;
    logic          chk;
    sharp_result_t exp_res;
  } stim_row_t;

  localparam sharp_result_t NO_RES = '0;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [23:0]      in_tdata;
  logic             in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [11:0]      cfg_data;

  rgb_sharpen_3x3_filter_unit #(
    .MAX_WIDTH(MAX_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Mirror of the filter state.
  logic [shp_pkg::CFG_W-1:0] width_reg;
  shp_pkg::pix_t             upper_buf [MAX_W];
  shp_pkg::pix_t             middle_buf [MAX_W];
  logic                      upper_ok [MAX_W];
  logic                      middle_ok [MAX_W];
  shp_pkg::pix_t             win [shp_pkg::WIN_SIZE];
  logic [COL_W-1:0]          col_cnt;
  logic [shp_pkg::ROW_W-1:0] row_cnt;

  sharp_result_t sharpened_q [$];
  int            mismatch_count;
  logic          squeeze_req;
  stim_row_t     dir_tbl [DIR_ROWS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int eff_width(input logic [shp_pkg::CFG_W-1:0] v);
    if (v < shp_pkg::WIDTH_MIN) return shp_pkg::WIDTH_MIN;
    if (v > MAX_W) return MAX_W;
    return int'(v);
  endfunction

  function automatic shp_pkg::chan_t sharpen_chan(input int sh);
    int acc;
    acc = 0;
    for (int k = 0; k < shp_pkg::WIN_SIZE; k++) begin
      if (k == shp_pkg::CENTER_IDX)
        acc += shp_pkg::CENTER_GAIN * int'(win[k][sh +: shp_pkg::CHAN_W]);
      else acc -= int'(win[k][sh +: shp_pkg::CHAN_W]);
    end
    if (acc < 0) acc = 0;
    if (acc > shp_pkg::CHAN_MAX) acc = shp_pkg::CHAN_MAX;
    return shp_pkg::chan_t'(acc);
  endfunction

  task automatic sharpen_step(input shp_pkg::pix_t p, input logic fs, output logic hit,
                              output sharp_result_t res);
    int            w;
    int            c;
    int            r;
    shp_pkg::pix_t top;
    shp_pkg::pix_t mid;
    w = eff_width(width_reg);
    if (fs) begin
      col_cnt = '0;
      row_cnt = '0;
    end
    c = int'(col_cnt);
    r = int'(row_cnt);
    top = upper_buf[c];
    mid = middle_buf[c];
    upper_buf[c] = mid;
    middle_buf[c] = p;
    upper_ok[c] = middle_ok[c];
    middle_ok[c] = 1'b1;
    // The window moves left by one column; rows run top to bottom.
    win[0] = win[1]; win[1] = win[2]; win[2] = top;
    win[3] = win[4]; win[4] = win[5]; win[5] = mid;
    win[6] = win[7]; win[7] = win[8]; win[8] = p;
    hit = (r >= 2) && (c >= 2);
    res.pix = {sharpen_chan(16), sharpen_chan(8), sharpen_chan(0)};
    res.col = COL_W'(c - 1);
    res.row = shp_pkg::ROW_W'(r - 1);
    if (c + 1 >= w) begin
      col_cnt = '0;
      if (row_cnt != shp_pkg::ROW_LIMIT) row_cnt = row_cnt + shp_pkg::ROW_W'(1);
    end else begin
      col_cnt = COL_W'(c + 1);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic shp_pkg::pix_t rand_pixel(input logic smooth, input shp_pkg::pix_t base);
    shp_pkg::pix_t p;
    int            sel;
    for (int ch = 0; ch < shp_pkg::NUM_CHAN; ch++) begin
      sel = $urandom_range(0, 9);
      if (smooth)
        p[ch*shp_pkg::CHAN_W +: shp_pkg::CHAN_W] =
          base[ch*shp_pkg::CHAN_W +: shp_pkg::CHAN_W] + 8'($urandom_range(0, 12));
      else if (sel < 2) p[ch*shp_pkg::CHAN_W +: shp_pkg::CHAN_W] = '0;
      else if (sel < 4) p[ch*shp_pkg::CHAN_W +: shp_pkg::CHAN_W] = '1;
      else p[ch*shp_pkg::CHAN_W +: shp_pkg::CHAN_W] = 8'($urandom);
    end
    return p;
  endfunction

  task automatic send_pixel(input shp_pkg::pix_t p, input logic fs, output logic hit);
    int            gap;
    sharp_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    in_tuser  <= fs;
    do @(posedge clk); while (!in_tready);
    sharpen_step(p, fs, hit, res);
    if (hit) sharpened_q.push_back(res);
  endtask

  task automatic run_frame(input int n_items, input logic new_frame, input int noise_pct);
    logic          smooth;
    shp_pkg::pix_t base;
    logic          fs;
    logic          hit;
    smooth = ($urandom_range(0, 2) == 0);
    base = {8'($urandom_range(0, 200)), 8'($urandom_range(0, 200)),
            8'($urandom_range(0, 200))};
    for (int i = 0; i < n_items; i++) begin
      fs = ((i == 0) && new_frame) || ($urandom_range(0, 99) < noise_pct);
      if ($urandom_range(0, 19) == 0) smooth = !smooth;
      send_pixel(rand_pixel(smooth, base), fs, hit);
    end
  endtask

  // The block may still hold a window with no result due, so keep waiting
  // after the last result beat.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sharpened_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [shp_pkg::CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    width_reg = v;
  endtask

  // Result side: checks every beat and stalls at random.
  initial begin
    sharp_result_t exp_res;
    sharp_result_t got;
    int            stall_left;
    int            hold_left;
    logic          squeeze_done;
    stall_left   = 0;
    hold_left    = 0;
    squeeze_done = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got.pix = out_tdata[shp_pkg::PIX_W-1:0];
        got.col = out_tdata[shp_pkg::PIX_W +: COL_W];
        got.row = out_tdata[shp_pkg::PIX_W + COL_W +: shp_pkg::ROW_W];
        if (sharpened_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result beat: pix=%h col=%0d row=%0d",
                     got.pix, got.col, got.row);
        end else begin
          exp_res = sharpened_q.pop_front();
          if (got.pix !== exp_res.pix || got.col !== exp_res.col ||
              got.row !== exp_res.row) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected pix=%h col=%0d row=%0d, got pix=%h col=%0d row=%0d",
                       exp_res.pix, exp_res.col, exp_res.row, got.pix, got.col, got.row);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (squeeze_req && !squeeze_done) begin
        // Long back-pressure so the pipeline fills and stalls the input.
        squeeze_done = 1'b1;
        hold_left = SQUEEZE_LEN;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    logic      hit;
    int        w;
    int        n;
    int        safe_cols;
    int        rand_items;
    int        r;
    stim_row_t row;
    mismatch_count = 0;
    squeeze_req = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    width_reg = shp_pkg::CFG_W'(shp_pkg::WIDTH_RESET);
    col_cnt   = '0;
    row_cnt   = '0;
    foreach (upper_buf[i]) begin
      upper_buf[i]  = '0;
      middle_buf[i] = '0;
      upper_ok[i]   = 1'b0;
      middle_ok[i]  = 1'b0;
    end
    foreach (win[i]) win[i] = '0;

    // Width 3: a lone bright center, then a dark center above a bright row,
    // then mixed and near-flat content and a frame start in mid-row.
    dir_tbl = '{
      '{24'h000000, 1'b1, 1'b0, NO_RES},
      '{24'h000000, 1'b0, 1'b0, NO_RES},
      '{24'h000000, 1'b0, 1'b0, NO_RES},
      '{24'h000000, 1'b0, 1'b0, NO_RES},
      '{24'hFFFFFF, 1'b0, 1'b0, NO_RES},
      '{24'h000000, 1'b0, 1'b0, NO_RES},
      '{24'h000000, 1'b0, 1'b0, NO_RES},
      '{24'h000000, 1'b0, 1'b0, NO_RES},
      '{24'h000000, 1'b0, 1'b1, '{24'hFFFFFF, 11'd1, 12'd1}},
      '{24'hFFFFFF, 1'b0, 1'b0, NO_RES},
      '{24'hFFFFFF, 1'b0, 1'b0, NO_RES},
      '{24'hFFFFFF, 1'b0, 1'b1, '{24'h000000, 11'd1, 12'd2}},
      '{24'h123456, 1'b0, 1'b0, NO_RES},
      '{24'h0000FF, 1'b0, 1'b0, NO_RES},
      '{24'h800000, 1'b0, 1'b0, NO_RES},
      '{24'h7F7F7F, 1'b0, 1'b0, NO_RES},
      '{24'h808080, 1'b0, 1'b0, NO_RES},
      '{24'h7F8081, 1'b0, 1'b0, NO_RES},
      '{24'h402010, 1'b0, 1'b0, NO_RES},
      '{24'h402010, 1'b1, 1'b0, NO_RES},
      '{24'h010203, 1'b0, 1'b0, NO_RES},
      '{24'hFEFDFC, 1'b0, 1'b0, NO_RES},
      '{24'h55AA55, 1'b0, 1'b0, NO_RES},
      '{24'hAA55AA, 1'b0, 1'b0, NO_RES},
      '{24'h3C3C3C, 1'b0, 1'b0, NO_RES}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // First pixels at the width left by reset; they all stay in the top row.
    run_frame(100 + $urandom_range(0, 20), 1'b1, 0);

    wait_idle();
    cfg_write(shp_pkg::CFG_W'(shp_pkg::WIDTH_MIN));
    foreach (dir_tbl[i]) begin
      row = dir_tbl[i];
      send_pixel(row.pix, row.fs, hit);
      if (row.chk) begin
        if (hit) sharpened_q[sharpened_q.size() - 1] = row.exp_res;
        else sharpened_q.push_back(row.exp_res);
      end
    end

    // The result side holds off while this frame keeps streaming in.
    squeeze_req = 1'b1;
    run_frame(60, 1'b1, 0);

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        // Width change inside a frame, kept to columns that both line
        // buffers already hold so no stale entry reaches a result.
        safe_cols = 0;
        while (safe_cols < MAX_W && upper_ok[safe_cols] && middle_ok[safe_cols])
          safe_cols++;
        if (safe_cols >= shp_pkg::WIDTH_MIN && int'(col_cnt) < safe_cols) begin
          wait_idle();
          w = $urandom_range(shp_pkg::WIDTH_MIN, (safe_cols < 40) ? safe_cols : 40);
          if (w == shp_pkg::WIDTH_MIN && $urandom_range(0, 1) == 0)
            cfg_write(shp_pkg::CFG_W'($urandom_range(0, 2)));
          else cfg_write(shp_pkg::CFG_W'(w));
          n = w * $urandom_range(1, 4) + $urandom_range(0, w - 1);
          run_frame(n, 1'b0, 2);
          rand_items += n;
        end
      end else begin
        if (r < 90) begin
          wait_idle();
          r = $urandom_range(0, 99);
          if (r < 8) cfg_write(shp_pkg::CFG_W'($urandom_range(0, 2)));
          else if (r < 75) cfg_write(shp_pkg::CFG_W'($urandom_range(3, 10)));
          else if (r < 93) cfg_write(shp_pkg::CFG_W'($urandom_range(11, 40)));
          else cfg_write(shp_pkg::CFG_W'($urandom_range(41, 120)));
        end
        w = eff_width(width_reg);
        n = w * $urandom_range(2, 6) + $urandom_range(0, w - 1);
        run_frame(n, 1'b1, 2);
        rand_items += n;
      end
    end

    // Register all ones: the width saturates at the line buffer depth, so a
    // short run stays inside the top row.
    wait_idle();
    cfg_write('1);
    run_frame(60 + $urandom_range(0, 20), 1'b1, 0);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
